/* rtl/bmw_hash_compression_core_defines.svh */
// assertion macros for the compression core
// no dependencies
`ifndef BMW_HASH_COMPRESSION_CORE_DEFINES_SVH
`define BMW_HASH_COMPRESSION_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BMW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define BMW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bmw_pkg.sv */
// types, constant tables and word functions of the compression core
// no dependencies
`default_nettype none
package bmw_pkg;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_DIGEST_MODE = 3'd0;

  localparam logic [1:0] MODE_224 = 2'd0;
  localparam logic [1:0] MODE_256 = 2'd1;
  localparam logic [1:0] MODE_384 = 2'd2;
  localparam logic [1:0] MODE_512 = 2'd3;

  localparam logic [63:0] KC64 = 64'h0555555555555555;
  localparam logic [31:0] KC32 = 32'h05555555;

  typedef enum logic [2:0] {
    TF_ID, TF_SFN, TF_ROL, TF_SHL, TF_SHR
  } tf_t;

  typedef enum logic [1:0] {
    OP_ADD, OP_SUB, OP_XOR
  } op_t;

  typedef struct packed {
    tf_t        tf;
    logic [5:0] amt;
    op_t        op;
    logic       wide;
  } alu_ctl_t;

  localparam logic signed [5:0] WMIX [16][5] = '{
    '{ 6, -8, 11, 14, 15}, '{ 7, -9, 12, 15,-16}, '{ 1,  8, 10,-13, 16},
    '{ 1, -2,  9,-11, 14}, '{ 2,  3, 10,-12,-15}, '{ 4, -3, 11,-13, 16},
    '{ 5, -1, -4,-12, 14}, '{ 2, -5, -6,-13,-15}, '{ 3, -6, -7, 14,-16},
    '{ 1, -4,  7, -8, 15}, '{ 9, -2, -5, -8, 16}, '{ 9, -1, -3, -6, 10},
    '{ 2,  4, -7,-10, 11}, '{ 3,  5,  8, 11, 12}, '{ 4, -6,  9,-12,-13},
    '{13, -5, -7,-10, 14}
  };

  localparam logic [5:0] SROT32 [4][2] = '{'{4, 19}, '{8, 23}, '{12, 25}, '{15, 29}};
  localparam logic [5:0] SROT64 [4][2] = '{'{4, 37}, '{13, 43}, '{19, 53}, '{28, 59}};
  localparam logic [5:0] SSH [4][2] = '{'{1, 3}, '{1, 2}, '{2, 1}, '{2, 2}};
  localparam logic [5:0] RROT32 [7] = '{3, 7, 13, 16, 19, 23, 27};
  localparam logic [5:0] RROT64 [7] = '{5, 11, 27, 32, 37, 43, 53};
  localparam logic [2:0] S1MAP [4] = '{3'd1, 3'd2, 3'd3, 3'd0};

  localparam logic       XHSH_L [8] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam logic [5:0] XHSH_N [8] = '{5, 7, 5, 1, 3, 6, 4, 11};
  localparam logic       QSH_L  [8] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam logic [5:0] QSH_N  [8] = '{5, 8, 5, 5, 0, 6, 6, 2};
  localparam logic       XLSH_L [8] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam logic [5:0] XLSH_N [8] = '{8, 6, 6, 4, 3, 4, 7, 2};

  function automatic logic [63:0] wmask(input logic wide);
    return wide ? 64'hFFFFFFFFFFFFFFFF : 64'h00000000FFFFFFFF;
  endfunction

  function automatic logic [63:0] rol(input logic [63:0] x, input logic [5:0] n,
                                      input logic wide);
    logic [31:0] x32;
    logic [31:0] r32;
    x32 = x[31:0];
    r32 = (x32 << n[4:0]) | (x32 >> (6'd32 - {1'b0, n[4:0]}));
    if (wide) begin
      return (x << n) | (x >> (7'd64 - {1'b0, n}));
    end
    return {32'h0, r32};
  endfunction

  function automatic logic [63:0] sfn(input logic [63:0] x, input logic [2:0] k,
                                      input logic wide);
    logic [63:0] m;
    logic [63:0] xm;
    logic [5:0]  r0;
    logic [5:0]  r1;
    m  = wmask(wide);
    xm = x & m;
    if (k == 3'd4) begin
      return (xm >> 1) ^ xm;
    end
    if (k == 3'd5) begin
      return (xm >> 2) ^ xm;
    end
    r0 = wide ? SROT64[k[1:0]][0] : SROT32[k[1:0]][0];
    r1 = wide ? SROT64[k[1:0]][1] : SROT32[k[1:0]][1];
    return ((xm >> SSH[k[1:0]][0]) ^ (xm << SSH[k[1:0]][1]) ^
            rol(xm, r0, wide) ^ rol(xm, r1, wide)) & m;
  endfunction

  // byte-sequence iv word k of the chosen mode
  function automatic logic [63:0] iv_word(input logic [3:0] k, input logic wide,
                                          input logic high);
    logic [7:0] b64;
    logic [7:0] b32;
    b64 = {1'b0, k, 3'b000};
    b32 = {2'b00, k, 2'b00};
    if (wide) begin
      return (high ? 64'h8081828384858687 : 64'h0001020304050607) + {8{b64}};
    end
    return {32'h0, (high ? 32'h40414243 : 32'h00010203) + {4{b32}}};
  endfunction

endpackage
`default_nettype wire

/* rtl/bmw_alu.sv */
// shared word unit: transform of one operand, then add, subtract or xor
// depends on bmw_pkg
`default_nettype none
module bmw_alu (
  input  bmw_pkg::alu_ctl_t ctl,
  input  logic [63:0]       a,
  input  logic [63:0]       x,
  output logic [63:0]       y
);
  import bmw_pkg::*;

  logic [63:0] m;
  logic [63:0] xm;
  logic [63:0] f;

  always_comb begin
    m  = wmask(ctl.wide);
    xm = x & m;
    unique case (ctl.tf)
      TF_SFN:  f = sfn(xm, ctl.amt[2:0], ctl.wide);
      TF_ROL:  f = rol(xm, ctl.amt, ctl.wide);
      TF_SHL:  f = (xm << ctl.amt) & m;
      TF_SHR:  f = xm >> ctl.amt;
      default: f = xm;
    endcase
    unique case (ctl.op)
      OP_SUB:  y = (a - f) & m;
      OP_XOR:  y = (a ^ f) & m;
      default: y = (a + f) & m;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/bmw_hash_compression_core.sv */
// compression core top: apb register, word buffer, sequencer and digest output
// depends on bmw_pkg, bmw_alu and bmw_hash_compression_core_defines.svh
//
//  channel  | handshake                  | payload
//  word     | word_valid / word_stall    | message_word, first_block, last_block
//  digest   | digest_valid / digest_stall| digest_word, digest_last
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata
//
// one word is taken per cycle while loading; the sixteenth word starts a
// compression through the word mix, expansion, xor and finish steps on the one shared alu
// word_stall stays high during compression and while digest words are queued
// the output register holds one digest word, a stall on it only delays it
// synchronous reset clears control, buffers and chaining value are not cleared
`default_nettype none
`include "bmw_hash_compression_core_defines.svh"
module bmw_hash_compression_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [63:0]                message_word,
  input  logic                       first_block,
  input  logic                       last_block,
  input  logic                       word_valid,
  output logic                       word_stall,
  output logic [63:0]                digest_word,
  output logic                       digest_last,
  output logic                       digest_valid,
  input  logic                       digest_stall,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bmw_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bmw_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_WMIX = 6'b000010,
    S_EXP  = 6'b000100,
    S_XOR  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t      state;
  logic [1:0]  mode;
  logic [1:0]  mode_l;
  logic        wide;
  logic        iv_flag;
  logic        last_l;
  logic [3:0]  widx;
  logic [4:0]  i;
  logic [4:0]  j;
  logic [2:0]  r5;
  logic [3:0]  oc;
  logic [63:0] acc;
  logic [63:0] tmp;
  logic [63:0] xl;
  logic [63:0] xh;
  logic [63:0] mw [16];
  logic [63:0] h [16];
  logic [63:0] q [32];

  logic [3:0]  ma;
  logic [3:0]  ha;
  logic [4:0]  qa;
  logic [63:0] mw_rd;
  logic [63:0] h_rd;
  logic [63:0] q_rd;
  logic [63:0] alu_a;
  logic [63:0] alu_x;
  logic [63:0] alu_y;
  alu_ctl_t    ctl;
  logic        accept;
  logic        cfg_wr;
  logic        fin_last;
  logic        out_load;
  logic [2:0]  kk;
  logic signed [5:0] wv;
  logic [3:0]  start;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign prdata     = (paddr == REG_DIGEST_MODE) ? {30'h0, mode} : 32'h0;
  assign word_stall = (state != S_LOAD);
  assign accept     = word_valid && !word_stall;
  assign out_load   = (state == S_OUT) && (!digest_valid || !digest_stall);
  assign kk         = i[2:0];
  assign fin_last   = i[3] ? (j == 5'd6) : (j == 5'd4);
  assign wv         = WMIX[i[3:0]][j[2:0]];
  assign mw_rd      = mw[ma];
  assign h_rd       = h[ha];
  assign q_rd       = q[qa];

  always_comb begin
    unique case (mode_l)
      MODE_224: start = 4'd9;
      MODE_384: start = 4'd10;
      default:  start = 4'd8;
    endcase
  end

  // operand selection per sequencer step
  always_comb begin
    ma    = '0;
    ha    = '0;
    qa    = '0;
    alu_a = '0;
    alu_x = '0;
    ctl   = '{tf: TF_ID, amt: 6'd0, op: OP_ADD, wide: wide};
    unique case (state)
      S_WMIX: begin
        if (j == 5'd5) begin
          alu_x   = acc;
          ctl.tf  = TF_SFN;
          ctl.amt = {3'b000, r5};
        end else begin
          ma     = 4'(wv < 0 ? -wv - 6'sd1 : wv - 6'sd1);
          ha     = ma;
          alu_x  = mw_rd ^ (iv_flag ? iv_word(ha, wide, mode_l[0]) : (h_rd & wmask(wide)));
          alu_a  = (j == 5'd0) ? 64'h0 : acc;
          ctl.op = (wv < 0) ? OP_SUB : OP_ADD;
        end
      end
      S_EXP: begin
        alu_a = (j == 5'd0) ? 64'h0 : acc;
        if (j < 5'd16) begin
          qa    = 5'({1'b0, i[3:0]} + j);
          alu_x = q_rd;
          if (i < 5'd18) begin
            ctl.tf  = TF_SFN;
            ctl.amt = {3'b000, S1MAP[j[1:0]]};
          end else if (j == 5'd14) begin
            ctl.tf  = TF_SFN;
            ctl.amt = 6'd5;
          end else if (j == 5'd15) begin
            ctl.tf  = TF_SFN;
            ctl.amt = 6'd4;
          end else if (j[0]) begin
            ctl.tf  = TF_ROL;
            ctl.amt = wide ? RROT64[j[3:1]] : RROT32[j[3:1]];
          end
        end else if (j == 5'd16) begin
          ma    = i[3:0];
          alu_x = mw_rd;
        end else if (j == 5'd17) begin
          ma    = i[3:0] + 4'd3;
          alu_x = mw_rd;
        end else if (j == 5'd18) begin
          ma     = i[3:0] + 4'd10;
          alu_x  = mw_rd;
          ctl.op = OP_SUB;
        end else begin
          alu_x = wide ? (64'(i) * KC64) : {32'h0, 32'(i) * KC32};
        end
      end
      S_XOR: begin
        qa     = {1'b1, j[3:0]};
        alu_x  = q_rd;
        alu_a  = (j == 5'd0) ? 64'h0 : acc;
        ctl.op = OP_XOR;
      end
      S_FIN: begin
        ctl.op = OP_XOR;
        ma     = i[3:0];
        if (!i[3]) begin
          unique case (j)
            5'd0: begin
              alu_x   = xh;
              alu_a   = mw_rd;
              ctl.tf  = XHSH_L[kk] ? TF_SHL : TF_SHR;
              ctl.amt = XHSH_N[kk];
            end
            5'd1: begin
              qa      = {2'b10, kk};
              alu_x   = q_rd;
              alu_a   = tmp;
              ctl.tf  = QSH_L[kk] ? TF_SHL : TF_SHR;
              ctl.amt = QSH_N[kk];
            end
            5'd2: begin
              qa    = {2'b11, kk};
              alu_x = q_rd;
              alu_a = xl;
            end
            5'd3: begin
              qa    = {2'b00, kk};
              alu_x = q_rd;
              alu_a = acc;
            end
            default: begin
              alu_x  = acc;
              alu_a  = tmp;
              ctl.op = OP_ADD;
            end
          endcase
        end else begin
          unique case (j)
            5'd0: begin
              alu_x = mw_rd;
              alu_a = xh;
            end
            5'd1: begin
              qa    = {2'b11, kk};
              alu_x = q_rd;
              alu_a = tmp;
            end
            5'd2: begin
              alu_x   = xl;
              ctl.tf  = XLSH_L[kk] ? TF_SHL : TF_SHR;
              ctl.amt = XLSH_N[kk];
            end
            5'd3: begin
              qa    = {2'b10, 3'(kk + 3'd7)};
              alu_x = q_rd;
              alu_a = acc;
            end
            5'd4: begin
              qa    = {2'b01, kk};
              alu_x = q_rd;
              alu_a = acc;
            end
            5'd5: begin
              alu_x  = tmp;
              alu_a  = acc;
              ctl.op = OP_ADD;
            end
            default: begin
              ha      = {1'b0, 3'(kk + 3'd4)};
              alu_x   = h_rd;
              alu_a   = acc;
              ctl.op  = OP_ADD;
              ctl.tf  = TF_ROL;
              ctl.amt = 6'd9 + {3'b000, kk};
            end
          endcase
        end
      end
      S_OUT: begin
        ha = oc;
      end
      default: begin
        ma = widx;
      end
    endcase
  end

  bmw_alu u_alu (
    .ctl (ctl),
    .a   (alu_a),
    .x   (alu_x),
    .y   (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      mode         <= MODE_256;
      mode_l       <= MODE_256;
      wide         <= 1'b0;
      iv_flag      <= 1'b0;
      last_l       <= 1'b0;
      widx         <= '0;
      i            <= '0;
      j            <= '0;
      r5           <= '0;
      oc           <= '0;
      digest_valid <= 1'b0;
    end else begin
      if (cfg_wr && paddr == REG_DIGEST_MODE) begin
        mode <= pwdata[1:0];
      end
      if (digest_valid && !digest_stall) begin
        digest_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            mw[widx] <= message_word & wmask(mode[1]);
            widx     <= widx + 4'd1;
            if (widx == 4'd15) begin
              wide    <= mode[1];
              mode_l  <= mode;
              iv_flag <= first_block;
              last_l  <= last_block;
              i       <= '0;
              j       <= '0;
              r5      <= '0;
              state   <= S_WMIX;
            end
          end
        end
        S_WMIX: begin
          if (j == 5'd5) begin
            q[i]  <= alu_y;
            j     <= '0;
            r5    <= (r5 == 3'd4) ? 3'd0 : r5 + 3'd1;
            i     <= i + 5'd1;
            if (i == 5'd15) begin
              state <= S_EXP;
            end
          end else begin
            acc <= alu_y;
            j   <= j + 5'd1;
          end
        end
        S_EXP: begin
          if (j == 5'd20) begin
            q[i] <= acc;
            j    <= '0;
            i    <= i + 5'd1;
            if (i == 5'd31) begin
              state <= S_XOR;
            end
          end else begin
            acc <= alu_y;
            j   <= j + 5'd1;
          end
        end
        S_XOR: begin
          acc <= alu_y;
          j   <= j + 5'd1;
          if (j == 5'd7) begin
            xl <= alu_y;
          end
          if (j == 5'd15) begin
            xh    <= alu_y;
            i     <= '0;
            j     <= '0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_last) begin
            h[i[3:0]] <= alu_y;
            j         <= '0;
            i         <= i + 5'd1;
            if (i == 5'd15) begin
              iv_flag <= 1'b0;
              oc      <= start;
              state   <= last_l ? S_OUT : S_LOAD;
            end
          end else begin
            j <= j + 5'd1;
            if (j <= 5'd1) begin
              tmp <= alu_y;
            end else begin
              acc <= alu_y;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            digest_word  <= h_rd & wmask(wide);
            digest_last  <= (oc == 4'd15);
            digest_valid <= 1'b1;
            oc           <= oc + 4'd1;
            if (oc == 4'd15) begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `BMW_ASSERT_NEXT(a_block_starts, clk, rst, accept && widx == 4'd15, state == S_WMIX, "full block did not start compression")
  `BMW_ASSERT_NOW(a_digest_from_out, clk, rst, $rose(digest_valid), $past(state == S_OUT), "digest word raised outside output phase")
  `BMW_ASSERT_NEXT(a_fin_to_load, clk, rst, state == S_FIN && fin_last && i == 5'd15 && !last_l, state == S_LOAD, "non-final block did not return to loading")
  `BMW_ASSERT_NOW(a_last_word_top, clk, rst, digest_valid && digest_last, oc == 4'd0 && state != S_OUT, "final digest word while output pending")

endmodule
`default_nettype wire
